FILE: design/nrdl_pkg.sv
// ----------------------------------------------------------------------------
// nrdl_pkg
// Shared types and defaults for the name registry: request opcodes, reply
// status codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nrdl_pkg;

    localparam int NUM_ENTRIES_DEF = 64;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int ID_BITS_DEF     = 8;

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_LOOKUP   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ACK    = 2'd0,
        ST_ANSWER = 2'd1,
        ST_TFULL  = 2'd2,
        ST_WFULL  = 2'd3
    } t_status;

    // which reply the datapath builds on an emit
    typedef enum logic [2:0] {
        E_ACK,
        E_TFULL,
        E_WFULL,
        E_HIT,
        E_WAKE
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  ent_rd;
        logic  ent_wr;
        logic  ent_grow;
        logic  hit_latch;
        logic  w_rd;
        logic  w_wr;
        logic  w_keep;
        logic  w_grow;
        logic  w_set;
        logic  emit;
        t_emit kind;
        logic  finish;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic ent_match;
        logic w_match;
        logic ent_full;
        logic wait_full;
        logic can_emit;
        logic can_finish;
    } t_dp_sts;

endpackage

FILE: design/name_registry_with_deferred_lookup.sv
// ----------------------------------------------------------------------------
// name_registry_with_deferred_lookup
// Name-to-task registry with a wait list of unanswered lookups.
// ----------------------------------------------------------------------------
// One request is handled at a time. The entry table is searched one entry per
// cycle through its single read port, and a register request then walks the
// wait list, reading each waiter and then answering or compacting it. While
// the output is stalled and a reply is already held, the walk and the closing
// reply wait for as long as the stall lasts. Replies pass through a one-deep
// hold stage so the final one of each request carries last. A full table
// returns status 2, a full wait list status 3.
// ----------------------------------------------------------------------------
module name_registry_with_deferred_lookup
    import nrdl_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_requester_id,
    input  logic [63:0] i_name_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_reply_task,
    output logic [7:0]  o_reply_value,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int ENT_CW  = $clog2(NUM_ENTRIES + 1);
    localparam int ENT_AW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
    localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    logic [ENT_AW-1:0]  w_ent_addr;
    logic [WAIT_AW-1:0] w_w_addr;
    logic [WAIT_CW-1:0] w_w_kept;
    logic [ENT_CW-1:0]  w_ent_count;
    logic [WAIT_CW-1:0] w_wait_count;

    nrdl_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .WAIT_DEPTH  (WAIT_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sts        (w_sts),
        .i_ent_count  (w_ent_count),
        .i_wait_count (w_wait_count),
        .o_cmd        (w_cmd),
        .o_ent_addr   (w_ent_addr),
        .o_w_addr     (w_w_addr),
        .o_w_kept     (w_w_kept)
    );

    nrdl_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .KEY_BYTES   (KEY_BYTES),
        .WAIT_DEPTH  (WAIT_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_ent_addr     (w_ent_addr),
        .i_w_addr       (w_w_addr),
        .i_w_kept       (w_w_kept),
        .o_sts          (w_sts),
        .o_ent_count    (w_ent_count),
        .o_wait_count   (w_wait_count),
        .i_opcode       (i_opcode),
        .i_requester_id (i_requester_id),
        .i_name_key     (i_name_key),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reply_task   (o_reply_task),
        .o_reply_value  (o_reply_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

FILE: design/nrdl_dp.sv
// ----------------------------------------------------------------------------
// nrdl_dp
// Datapath: entry table and wait list memories, captured request, counts,
// key compares, and a one-deep hold stage ahead of the output register so the
// final reply of a request can be flagged last.
// ----------------------------------------------------------------------------
module nrdl_dp
    import nrdl_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    localparam int ENT_CW     = $clog2(NUM_ENTRIES + 1),
    localparam int ENT_AW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
    localparam int WAIT_CW    = $clog2(WAIT_DEPTH + 1),
    localparam int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [ENT_AW-1:0]  i_ent_addr,
    input  logic [WAIT_AW-1:0] i_w_addr,
    input  logic [WAIT_CW-1:0] i_w_kept,
    output t_dp_sts            o_sts,
    output logic [ENT_CW-1:0]  o_ent_count,
    output logic [WAIT_CW-1:0] o_wait_count,
    input  logic               i_opcode,
    input  logic [7:0]         i_requester_id,
    input  logic [63:0]        i_name_key,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_reply_task,
    output logic [7:0]         o_reply_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int KB = KEY_BYTES * 8;
    localparam int EW = KB + ID_BITS;

    logic [EW-1:0]      r_ent_mem [NUM_ENTRIES];
    logic [EW-1:0]      r_wait_mem [WAIT_DEPTH];
    logic [EW-1:0]      r_ent_rd;
    logic [EW-1:0]      r_w_rd;
    logic [EW-1:0]      w_w_wdata;

    t_op                r_op;
    logic [ID_BITS-1:0] r_req;
    logic [KB-1:0]      r_key;
    logic [ID_BITS-1:0] r_owner;
    logic [ENT_CW-1:0]  r_ent_count;
    logic [WAIT_CW-1:0] r_wait_count;

    logic               r_hold_v;
    logic [7:0]         r_hold_tgt;
    logic [7:0]         r_hold_val;
    t_status            r_hold_st;
    logic               r_out_v;
    logic [7:0]         r_out_tgt;
    logic [7:0]         r_out_val;
    t_status            r_out_st;
    logic               r_out_last;

    logic [ID_BITS+7:0] w_req_in;
    logic [ID_BITS+7:0] w_req_ext;
    logic [ID_BITS+7:0] w_own_ext;
    logic [ID_BITS+7:0] w_wid_ext;
    logic [7:0]         w_em_tgt;
    logic [7:0]         w_em_val;
    t_status            w_em_st;
    logic               w_out_free;
    logic               w_out_load;

    // id width conversions both ways
    assign w_req_in  = {{ID_BITS{1'b0}}, i_requester_id};
    assign w_req_ext = {8'd0, r_req};
    assign w_own_ext = {8'd0, r_owner};
    assign w_wid_ext = {8'd0, r_w_rd[ID_BITS-1:0]};

    assign w_out_free = !r_out_v || i_ready;
    assign w_out_load = (i_cmd.emit && r_hold_v) || i_cmd.finish;

    assign o_sts.op         = r_op;
    assign o_sts.ent_match  = (r_ent_rd[EW-1:ID_BITS] == r_key);
    assign o_sts.w_match    = (r_w_rd[EW-1:ID_BITS] == r_key);
    assign o_sts.ent_full   = (r_ent_count == ENT_CW'(NUM_ENTRIES));
    assign o_sts.wait_full  = (r_wait_count == WAIT_CW'(WAIT_DEPTH));
    assign o_sts.can_emit   = !r_hold_v || w_out_free;
    assign o_sts.can_finish = w_out_free;

    assign o_ent_count  = r_ent_count;
    assign o_wait_count = r_wait_count;

    assign w_w_wdata = i_cmd.w_keep ? r_w_rd : {r_key, r_req};

    always_comb begin
        w_em_tgt = w_req_ext[7:0];
        w_em_val = 8'd0;
        w_em_st  = ST_ACK;
        case (i_cmd.kind)
            E_ACK:   w_em_st = ST_ACK;
            E_TFULL: w_em_st = ST_TFULL;
            E_WFULL: w_em_st = ST_WFULL;
            E_HIT: begin
                w_em_val = w_own_ext[7:0];
                w_em_st  = ST_ANSWER;
            end
            E_WAKE: begin
                w_em_tgt = w_wid_ext[7:0];
                w_em_val = w_req_ext[7:0];
                w_em_st  = ST_ANSWER;
            end
            default: w_em_st = ST_ACK;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_wr) begin
            r_ent_mem[i_ent_addr] <= {r_key, r_req};
        end
        if (i_cmd.ent_rd) begin
            r_ent_rd <= r_ent_mem[i_ent_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_wr) begin
            r_wait_mem[i_w_addr] <= w_w_wdata;
        end
        if (i_cmd.w_rd) begin
            r_w_rd <= r_wait_mem[i_w_addr];
        end
    end

    // request capture and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_opcode);
            r_req <= w_req_in[ID_BITS-1:0];
            r_key <= i_name_key[KB-1:0];
        end
        if (i_cmd.hit_latch) begin
            r_owner <= r_ent_rd[ID_BITS-1:0];
        end
        if (i_cmd.emit) begin
            r_hold_tgt <= w_em_tgt;
            r_hold_val <= w_em_val;
            r_hold_st  <= w_em_st;
        end
        if (w_out_load) begin
            r_out_tgt  <= r_hold_tgt;
            r_out_val  <= r_hold_val;
            r_out_st   <= r_hold_st;
            r_out_last <= i_cmd.finish;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_count  <= '0;
            r_wait_count <= '0;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cmd.ent_grow) begin
                r_ent_count <= r_ent_count + 1'b1;
            end
            if (i_cmd.w_set) begin
                r_wait_count <= i_w_kept;
            end else if (i_cmd.w_grow) begin
                r_wait_count <= r_wait_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hold_v <= 1'b0;
            end
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_reply_task  = r_out_tgt;
    assign o_reply_value = r_out_val;
    assign o_status      = r_out_st;
    assign o_last        = r_out_last;

`ifndef NO_ASSERTIONS
    a_ent_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ent_count <= ENT_CW'(NUM_ENTRIES))
        else $error("entry count past table size");

    a_wait_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait_count <= WAIT_CW'(WAIT_DEPTH))
        else $error("wait count past list depth");

    a_finish_has_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_hold_v)
        else $error("finish with empty hold stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_out_tgt) && $stable(r_out_val)))
        else $error("stalled reply overwritten");
`endif

endmodule

FILE: design/nrdl_ctrl.sv
// ----------------------------------------------------------------------------
// nrdl_ctrl
// Controller: scans the entry table (one read in flight), applies the request,
// then after a stored register wakes matching waiters and compacts the rest.
// ----------------------------------------------------------------------------
module nrdl_ctrl
    import nrdl_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    localparam int ENT_CW     = $clog2(NUM_ENTRIES + 1),
    localparam int ENT_AW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
    localparam int WAIT_CW    = $clog2(WAIT_DEPTH + 1),
    localparam int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_dp_sts            i_sts,
    input  logic [ENT_CW-1:0]  i_ent_count,
    input  logic [WAIT_CW-1:0] i_wait_count,
    output t_dp_cmd            o_cmd,
    output logic [ENT_AW-1:0]  o_ent_addr,
    output logic [WAIT_AW-1:0] o_w_addr,
    output logic [WAIT_CW-1:0] o_w_kept
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ESCAN,
        S_ACT,
        S_WRD,
        S_WCHK,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [ENT_CW-1:0]  r_eidx, n_eidx;
    logic [ENT_AW-1:0]  r_eidx_p, n_eidx_p;
    logic               r_epend, n_epend;
    logic               r_hit, n_hit;
    logic [ENT_AW-1:0]  r_hit_idx, n_hit_idx;
    logic [WAIT_CW-1:0] r_widx, n_widx;
    logic [WAIT_CW-1:0] r_kept, n_kept;

    always_comb begin
        n_state    = r_state;
        n_eidx     = r_eidx;
        n_eidx_p   = r_eidx_p;
        n_epend    = r_epend;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_widx     = r_widx;
        n_kept     = r_kept;
        o_cmd      = '0;
        o_ent_addr = r_eidx[ENT_AW-1:0];
        o_w_addr   = r_widx[WAIT_AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_eidx        = '0;
                    n_epend       = 1'b0;
                    n_state       = S_ESCAN;
                end
            end
            S_ESCAN: begin
                // the compare sees the entry read issued in the previous cycle
                if (r_epend && i_sts.ent_match) begin
                    o_cmd.hit_latch = 1'b1;
                    n_hit           = 1'b1;
                    n_hit_idx       = r_eidx_p;
                    n_epend         = 1'b0;
                    n_state         = S_ACT;
                end else if (r_eidx < i_ent_count) begin
                    o_cmd.ent_rd = 1'b1;
                    n_epend      = 1'b1;
                    n_eidx_p     = r_eidx[ENT_AW-1:0];
                    n_eidx       = r_eidx + 1'b1;
                end else begin
                    n_hit   = 1'b0;
                    n_epend = 1'b0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_widx = '0;
                n_kept = '0;
                if (i_sts.op == OP_REGISTER) begin
                    if (r_hit) begin
                        o_cmd.ent_wr = 1'b1;
                        o_ent_addr   = r_hit_idx;
                        o_cmd.emit   = 1'b1;
                        o_cmd.kind   = E_ACK;
                        n_state      = S_WRD;
                    end else if (!i_sts.ent_full) begin
                        o_cmd.ent_wr   = 1'b1;
                        o_cmd.ent_grow = 1'b1;
                        o_ent_addr     = i_ent_count[ENT_AW-1:0];
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = E_ACK;
                        n_state        = S_WRD;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = E_TFULL;
                        n_state    = S_FIN;
                    end
                end else begin
                    if (r_hit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = E_HIT;
                        n_state    = S_FIN;
                    end else if (!i_sts.wait_full) begin
                        // miss: park the requester, nothing to reply yet
                        o_cmd.w_wr   = 1'b1;
                        o_cmd.w_grow = 1'b1;
                        o_w_addr     = i_wait_count[WAIT_AW-1:0];
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = E_WFULL;
                        n_state    = S_FIN;
                    end
                end
            end
            S_WRD: begin
                if (r_widx < i_wait_count) begin
                    o_cmd.w_rd = 1'b1;
                    n_state    = S_WCHK;
                end else begin
                    o_cmd.w_set = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_WCHK: begin
                if (i_sts.w_match) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = E_WAKE;
                        n_widx     = r_widx + 1'b1;
                        n_state    = S_WRD;
                    end
                end else begin
                    o_cmd.w_wr   = 1'b1;
                    o_cmd.w_keep = 1'b1;
                    o_w_addr     = r_kept[WAIT_AW-1:0];
                    n_kept       = r_kept + 1'b1;
                    n_widx       = r_widx + 1'b1;
                    n_state      = S_WRD;
                end
            end
            S_FIN: begin
                if (i_sts.can_finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_epend <= 1'b0;
            r_hit   <= 1'b0;
            r_eidx  <= '0;
            r_widx  <= '0;
            r_kept  <= '0;
        end else begin
            r_state <= n_state;
            r_epend <= n_epend;
            r_hit   <= n_hit;
            r_eidx  <= n_eidx;
            r_widx  <= n_widx;
            r_kept  <= n_kept;
        end
        r_eidx_p  <= n_eidx_p;
        r_hit_idx <= n_hit_idx;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_w_kept = r_kept;

`ifndef NO_ASSERTIONS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.can_emit)
        else $error("reply emitted with no room");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epend |-> (r_state == S_ESCAN))
        else $error("entry read left in flight");

    a_grow_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ent_grow |-> (!r_hit && !i_sts.ent_full))
        else $error("table grown on hit or when full");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_widx)
        else $error("compaction index ahead of scan");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives register and lookup requests into the name registry and checks every
// reply against a predictor holding its own table and wait list. A directed
// opening covers extreme ids and keys, re-registration, keys that differ only
// above a zero byte, a full wait list and the widest flush. Random traffic then
// runs before, while and after the table fills, with bursty requests and a
// stalling reply side.
// ----------------------------------------------------------------------------
module testbench
    import nrdl_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        logic [7:0] to_task;
        logic [7:0] value;
        t_status    status;
        logic       last;
    } t_reply;

    typedef enum {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} t_rx_mode;

    class registry_scoreboard;
        logic [63:0] name_keys [NUM_ENTRIES_DEF];
        logic [7:0]  name_owners [NUM_ENTRIES_DEF];
        int          name_count;
        logic [7:0]  waiter_ids [$];
        logic [63:0] waiter_keys [$];
        t_reply      expected [$];
        int          errors;

        function new();
            name_count = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function int table_size();
            return name_count;
        endfunction

        function void push_reply(logic [7:0] to_task, logic [7:0] value, t_status status,
                                 logic last);
            t_reply r;
            r.to_task = to_task;
            r.value   = value;
            r.status  = status;
            r.last    = last;
            expected.push_back(r);
        endfunction

        // called once per accepted request
        function void note_request(t_op op, logic [7:0] req, logic [63:0] key);
            int          hit;
            logic [7:0]  woken [$];
            logic [7:0]  kept_ids [$];
            logic [63:0] kept_keys [$];
            hit = -1;
            for (int i = 0; i < name_count; i++)
                if (hit < 0 && name_keys[i] == key) hit = i;
            if (op == OP_REGISTER) begin
                if (hit >= 0) begin
                    name_owners[hit] = req;
                end else if (name_count < NUM_ENTRIES_DEF) begin
                    name_keys[name_count]   = key;
                    name_owners[name_count] = req;
                    name_count++;
                end else begin
                    push_reply(req, 8'd0, ST_TFULL, 1'b1);
                    return;
                end
                // answered waiters leave, the rest keep their order
                foreach (waiter_ids[i]) begin
                    if (waiter_keys[i] == key) begin
                        woken.push_back(waiter_ids[i]);
                    end else begin
                        kept_ids.push_back(waiter_ids[i]);
                        kept_keys.push_back(waiter_keys[i]);
                    end
                end
                waiter_ids  = kept_ids;
                waiter_keys = kept_keys;
                push_reply(req, 8'd0, ST_ACK, woken.size() == 0);
                foreach (woken[i])
                    push_reply(woken[i], req, ST_ANSWER, i == woken.size() - 1);
            end else if (hit >= 0) begin
                push_reply(req, name_owners[hit], ST_ANSWER, 1'b1);
            end else if (waiter_ids.size() < WAIT_DEPTH_DEF) begin
                waiter_ids.push_back(req);
                waiter_keys.push_back(key);
            end else begin
                push_reply(req, 8'd0, ST_WFULL, 1'b1);
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [7:0] to_task, logic [7:0] value, logic [1:0] status,
                                  logic last);
            t_reply want;
            if (expected.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual task %0h value %0h %s",
                         $time, to_task, value, $sformatf("status %0d last %0b", status, last));
                errors++;
                return;
            end
            want = expected.pop_front();
            compare_field("reply_task", want.to_task, to_task);
            compare_field("reply_value", want.value, value);
            compare_field("status", 8'(want.status), 8'(status));
            compare_field("last", 8'(want.last), 8'(last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [7:0]  i_requester_id;
    logic [63:0] i_name_key;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_reply_task;
    logic [7:0]  o_reply_value;
    logic [1:0]  o_status;
    logic        o_last;

    registry_scoreboard registry;
    logic [63:0]        key_pool [$];
    int                 burst_left;
    int                 rx_cycle = 0;
    int                 cycles;
    t_rx_mode           rx_mode = RX_OPEN;

    name_registry_with_deferred_lookup DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_requester_id (i_requester_id),
        .i_name_key     (i_name_key),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reply_task   (o_reply_task),
        .o_reply_value  (o_reply_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // zero-padded name of random length, so short and full-width keys both occur
    function automatic logic [63:0] fresh_key();
        int          nbytes;
        logic [63:0] k;
        nbytes = $urandom_range(1, 8);
        k      = {$urandom, $urandom};
        if (nbytes < 8) k = k & ((64'd1 << (8 * nbytes)) - 64'd1);
        return k;
    endfunction

    task automatic send_request(t_op op, logic [7:0] id, logic [63:0] key);
        int gap;
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_requester_id <= id;
        i_name_key     <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        registry.note_request(op, id, key);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic random_request(int register_pct, int fresh_pct);
        t_op         op;
        logic [63:0] key;
        op = ($urandom_range(0, 99) < register_pct) ? OP_REGISTER : OP_LOOKUP;
        if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
            key = fresh_key();
            key_pool.push_back(key);
        end else begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        send_request(op, 8'($urandom_range(0, 255)), key);
    endtask

    // reply side: check, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            registry.check_reply(o_reply_task, o_reply_value, o_status, o_last);
        rx_cycle++;
        if (rx_cycle % 200 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_EVERY4: i_ready <= (rx_cycle % 4 == 0);
            default:   i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [63:0] flood_key;
        registry       = new();
        burst_left     = $urandom_range(1, 12);
        flood_key      = 64'h0123_4567_89AB_CDEF;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_REGISTER;
        i_requester_id <= 8'd0;
        i_name_key     <= 64'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme keys and ids; the first two lookups are woken by a later register
        send_request(OP_LOOKUP, 8'h00, 64'd0);
        send_request(OP_LOOKUP, 8'hFF, '1);
        send_request(OP_REGISTER, 8'hFF, 64'd0);
        send_request(OP_REGISTER, 8'h00, '1);
        send_request(OP_LOOKUP, 8'h5A, 64'd0);
        send_request(OP_REGISTER, 8'hA5, 64'd0);
        // bytes above a zero byte still take part in the compare
        send_request(OP_LOOKUP, 8'h01, 64'h42);
        send_request(OP_REGISTER, 8'h02, 64'h0000_0041_0000_0042);
        send_request(OP_REGISTER, 8'h03, 64'h42);
        // fill the wait list on one key, overflow it, then flush it in one go
        for (int i = 0; i < WAIT_DEPTH_DEF; i++)
            send_request(OP_LOOKUP, 8'(16 + i), flood_key);
        send_request(OP_LOOKUP, 8'd200, flood_key);
        send_request(OP_REGISTER, 8'd77, flood_key);

        key_pool.push_back(64'd0);
        key_pool.push_back('1);
        key_pool.push_back(64'h42);
        key_pool.push_back(flood_key);

        for (int i = 0; i < 12; i++) random_request(55, 50);
        // fill the table with fresh names
        while (registry.table_size() < NUM_ENTRIES_DEF) random_request(95, 100);
        // table now full: new names are refused, misses pile up on the wait list
        for (int i = 0; i < 13; i++) random_request(50, 40);

        i_valid <= 1'b0;
        while (registry.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (registry.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: name_registry_with_deferred_lookup.f
design/nrdl_pkg.sv
design/nrdl_dp.sv
design/nrdl_ctrl.sv
design/name_registry_with_deferred_lookup.sv
dv/testbench.sv
